// ----- rtl/token_bucket_packet_shaper_macros.svh -----
// ----------------------------------------------------------------------------
// token bucket packet shaper assertion macros
// concurrent assertion helpers shared by the checker
// ----------------------------------------------------------------------------
`ifndef TOKEN_BUCKET_PACKET_SHAPER_MACROS_SVH
`define TOKEN_BUCKET_PACKET_SHAPER_MACROS_SVH

// same-cycle implication, disabled in reset
`define TBPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define TBPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tbps_pkg.sv -----
// ----------------------------------------------------------------------------
// tbps_pkg
// shared types and constants of the token bucket packet shaper
// ----------------------------------------------------------------------------
package tbps_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_TOKEN_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT = 2'd1;

    localparam int TOK_LIM_W = 10;
    localparam int Q_LIM_W   = 5;
    localparam int SIZE_W    = 6;
    localparam int TOTAL_W   = 32;

    localparam logic [TOK_LIM_W-1:0] TOKEN_LIMIT_RST = 10'd64;
    localparam logic [Q_LIM_W-1:0]   QUEUE_LIMIT_RST = 5'd16;

    // request kinds
    localparam logic REQ_TOKEN  = 1'b0;
    localparam logic REQ_PACKET = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic rd_en;
        logic commit;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_pkt;
    } t_ctrl_sts;

endpackage

// ----- rtl/token_bucket_packet_shaper.sv -----
// ----------------------------------------------------------------------------
// token_bucket_packet_shaper
// token bucket shaper with a packet size queue and saturating loss counters
// ----------------------------------------------------------------------------
//  channel   direction  handshake                       beat contents
//  s_axis    in         s_axis_tvalid / s_axis_tready   tuser req_type, tdata pkt_size
//  m_axis    out        m_axis_tvalid / m_axis_tready   tdata one result per input beat
//  cfg       in         i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
//  a packet arrival passes through the READ state, which a token tick skips;
//  it holds the registered read of the queue head from the size ram
//  next input beat is taken once the previous result is loaded in the output
//  register, which then waits for m_axis_tready without blocking new input
//  synchronous active-low reset, no clearing pass: queue entries are read
//  only after being written; cfg writes are taken every cycle
// ----------------------------------------------------------------------------
module token_bucket_packet_shaper
    import tbps_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TOKEN_WIDTH = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input beats
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,  // [5:0] pkt_size
    input  logic [0:0]            s_axis_tuser,  // [0] req_type
    // result beats
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] sent, [6:1] sent_size, [7] packet_lost, [8] token_rejected,
    // then tokens_held, queue_fill, lost_total, rejected_total
    output logic [((73 + TOKEN_WIDTH + $clog2(QUEUE_DEPTH + 1) + 7) / 8) * 8 - 1:0]
                                  m_axis_tdata,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_W = ((73 + TOKEN_WIDTH + CW + 7) / 8) * 8;

    t_ctrl_cmd w_cmd;
    t_ctrl_sts w_sts;

    // config registers are always writable
    assign o_cfg_ready = 1'b1;

    tbps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    tbps_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TOKEN_WIDTH (TOKEN_WIDTH),
        .OUT_W       (OUT_W)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_type   (s_axis_tuser[0]),
        .i_in_size   (s_axis_tdata[SIZE_W-1:0]),
        .i_cfg_wr    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (m_axis_tdata)
    );

endmodule

// ----- rtl/tbps_ram.sv -----
// ----------------------------------------------------------------------------
// tbps_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module tbps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/tbps_ctrl.sv -----
// ----------------------------------------------------------------------------
// tbps_ctrl
// sequencer of the shaper: accept, update, head read, release and result beat
// ----------------------------------------------------------------------------
module tbps_ctrl
    import tbps_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    input  t_ctrl_sts i_sts,
    output t_ctrl_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_READ  = 4'b0100,
        S_CHECK = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_commit;

    assign w_commit = (r_state == S_CHECK) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = i_sts.is_pkt ? S_READ : S_CHECK;
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (w_commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec    = (r_state == S_EXEC);
    assign o_cmd.rd_en   = (r_state == S_READ);
    assign o_cmd.commit  = w_commit;

endmodule

// ----- rtl/tbps_datapath.sv -----
// ----------------------------------------------------------------------------
// tbps_datapath
// token count, size queue, saturating counters, limits and result register
// ----------------------------------------------------------------------------
module tbps_datapath
    import tbps_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TOKEN_WIDTH = 10,
    parameter int OUT_W       = 88
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctrl_cmd             i_cmd,
    output t_ctrl_sts             o_sts,
    input  logic                  i_in_type,
    input  logic [SIZE_W-1:0]     i_in_size,
    input  logic                  i_cfg_wr,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [OUT_W-1:0]      o_result
);

    localparam int AW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int TLW = (TOKEN_WIDTH > TOK_LIM_W) ? TOKEN_WIDTH : TOK_LIM_W;
    localparam int SW  = (TOKEN_WIDTH > SIZE_W) ? TOKEN_WIDTH : SIZE_W;
    localparam int CLW = (CW > Q_LIM_W) ? CW : Q_LIM_W;

    logic [TOK_LIM_W-1:0]   r_tok_lim;
    logic [Q_LIM_W-1:0]     r_q_lim;
    logic                   r_type;
    logic [SIZE_W-1:0]      r_size;
    logic [TOKEN_WIDTH-1:0] r_tc;
    logic [AW-1:0]          r_head, r_tail;
    logic [CW-1:0]          r_cnt;
    logic [TOTAL_W-1:0]     r_lost_tot, r_rej_tot;
    logic                   r_lost_f, r_rej_f;

    logic                   r_o_sent, r_o_lost, r_o_rej;
    logic [SIZE_W-1:0]      r_o_size;
    logic [TOKEN_WIDTH-1:0] r_o_tc;
    logic [CW-1:0]          r_o_cnt;
    logic [TOTAL_W-1:0]     r_o_lost_tot, r_o_rej_tot;

    logic [SIZE_W-1:0]      w_rd_data;
    logic                   w_tok_room, w_q_room, w_release, w_wr_en;
    logic [TOKEN_WIDTH-1:0] w_tc_rel;
    logic [AW-1:0]          w_head_nxt, w_tail_nxt;

    assign w_tok_room = (r_tc != {TOKEN_WIDTH{1'b1}}) && (TLW'(r_tc) < TLW'(r_tok_lim));
    assign w_q_room   = (r_cnt < CW'(QUEUE_DEPTH)) && (CLW'(r_cnt) < CLW'(r_q_lim));
    assign w_wr_en    = i_cmd.exec && (r_type == REQ_PACKET) && w_q_room;
    assign w_release  = (r_type == REQ_PACKET) && (r_cnt != '0)
                        && (SW'(w_rd_data) <= SW'(r_tc));
    assign w_tc_rel   = TOKEN_WIDTH'(SW'(r_tc) - SW'(w_rd_data));
    assign w_head_nxt = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign w_tail_nxt = (r_tail == AW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;

    tbps_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_tail),
        .i_wr_data (r_size),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (r_head),
        .o_rd_data (w_rd_data)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_lim  <= TOKEN_LIMIT_RST;
            r_q_lim    <= QUEUE_LIMIT_RST;
            r_tc       <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_cnt      <= '0;
            r_lost_tot <= '0;
            r_rej_tot  <= '0;
        end else begin
            if (i_cfg_wr) begin
                case (i_cfg_index)
                    REG_TOKEN_LIMIT: r_tok_lim <= i_cfg_data[TOK_LIM_W-1:0];
                    REG_QUEUE_LIMIT: r_q_lim   <= i_cfg_data[Q_LIM_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.exec) begin
                if (r_type == REQ_TOKEN) begin
                    if (w_tok_room) begin
                        r_tc <= r_tc + 1'b1;
                    end else if (r_rej_tot != '1) begin
                        r_rej_tot <= r_rej_tot + 1'b1;
                    end
                end else begin
                    if (w_q_room) begin
                        r_tail <= w_tail_nxt;
                        r_cnt  <= r_cnt + 1'b1;
                    end else if (r_lost_tot != '1) begin
                        r_lost_tot <= r_lost_tot + 1'b1;
                    end
                end
            end
            if (i_cmd.commit && w_release) begin
                r_tc   <= w_tc_rel;
                r_head <= w_head_nxt;
                r_cnt  <= r_cnt - 1'b1;
            end
        end
    end

    // item, flags and result beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_type <= i_in_type;
            r_size <= i_in_size;
        end
        if (i_cmd.exec) begin
            r_lost_f <= (r_type == REQ_PACKET) && !w_q_room;
            r_rej_f  <= (r_type == REQ_TOKEN) && !w_tok_room;
        end
        if (i_cmd.commit) begin
            r_o_sent     <= w_release;
            r_o_size     <= w_release ? w_rd_data : '0;
            r_o_lost     <= r_lost_f;
            r_o_rej      <= r_rej_f;
            r_o_tc       <= w_release ? w_tc_rel : r_tc;
            r_o_cnt      <= w_release ? r_cnt - 1'b1 : r_cnt;
            r_o_lost_tot <= r_lost_tot;
            r_o_rej_tot  <= r_rej_tot;
        end
    end

    assign o_sts.is_pkt = (r_type == REQ_PACKET);
    assign o_result = OUT_W'({r_o_rej_tot, r_o_lost_tot, r_o_cnt, r_o_tc,
                              r_o_rej, r_o_lost, r_o_size, r_o_sent});

endmodule

// ----- rtl/tbps_checker.sv -----
// ----------------------------------------------------------------------------
// tbps_checker
// port-level assertions of the shaper, bound to the top level
// ----------------------------------------------------------------------------
`include "token_bucket_packet_shaper_macros.svh"

module tbps_checker
    import tbps_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TOKEN_WIDTH = 10
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [((73 + TOKEN_WIDTH + $clog2(QUEUE_DEPTH + 1) + 7) / 8) * 8 - 1:0]
                                 m_axis_tdata
);

    // stalled result beat holds
    `TBPS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result beat changed under stall")

    // one item in work at a time
    `TBPS_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while an item is in work")

    // no release means zero size
    `TBPS_ASSERT_NOW(a_size_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[6:1] == '0, "sent_size without release")

    // a beat is either a lost packet or a rejected token, never both
    `TBPS_ASSERT_NOW(a_flag_excl, i_clk, i_rst_n, m_axis_tvalid, !(m_axis_tdata[7] && m_axis_tdata[8]), "lost and rejected in one beat")

endmodule

bind token_bucket_packet_shaper tbps_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TOKEN_WIDTH (TOKEN_WIDTH)
) u_tbps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
